/* src/gray_alpha_quantize_pack_defines.svh */
`ifndef GRAY_ALPHA_QUANTIZE_PACK_DEFINES_SVH
`define GRAY_ALPHA_QUANTIZE_PACK_DEFINES_SVH

// Checks sampled on clk, suspended while rst_n is low.
`define GAQP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define GAQP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/gaqp_pkg.sv */
`default_nettype none

package gaqp_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GRAY_WIDTH     = 2'd0,
        CFG_ALPHA_WIDTH    = 2'd1,
        CFG_COLOR_CHANNELS = 2'd2
    } cfg_index_t;

    localparam logic [3:0] GRAY_WIDTH_RESET     = 4'd4;
    localparam logic [2:0] ALPHA_WIDTH_RESET    = 3'd0;
    localparam logic [1:0] COLOR_CHANNELS_RESET = 2'd3;

    localparam int unsigned RECIP_SHIFT = 20;
    localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
    localparam int unsigned RECIP_ONE   = 1 << RECIP_SHIFT;

    // ceil(2^20 / d) for the gray divisor (channels*255)/(2^bits-1)
    localparam logic [RECIP_W-1:0] GRAY_RECIP [3][8] = '{
        '{ RECIP_W'((RECIP_ONE + 254) / 255), RECIP_W'((RECIP_ONE + 84) / 85),
           RECIP_W'((RECIP_ONE + 35) / 36),   RECIP_W'((RECIP_ONE + 16) / 17),
           RECIP_W'((RECIP_ONE + 7) / 8),     RECIP_W'((RECIP_ONE + 3) / 4),
           RECIP_W'((RECIP_ONE + 1) / 2),     RECIP_W'(RECIP_ONE) },
        '{ RECIP_W'((RECIP_ONE + 509) / 510), RECIP_W'((RECIP_ONE + 169) / 170),
           RECIP_W'((RECIP_ONE + 71) / 72),   RECIP_W'((RECIP_ONE + 33) / 34),
           RECIP_W'((RECIP_ONE + 15) / 16),   RECIP_W'((RECIP_ONE + 7) / 8),
           RECIP_W'((RECIP_ONE + 3) / 4),     RECIP_W'((RECIP_ONE + 1) / 2) },
        '{ RECIP_W'((RECIP_ONE + 764) / 765), RECIP_W'((RECIP_ONE + 254) / 255),
           RECIP_W'((RECIP_ONE + 108) / 109), RECIP_W'((RECIP_ONE + 50) / 51),
           RECIP_W'((RECIP_ONE + 23) / 24),   RECIP_W'((RECIP_ONE + 11) / 12),
           RECIP_W'((RECIP_ONE + 5) / 6),     RECIP_W'((RECIP_ONE + 2) / 3) }
    };

    // ceil(2^20 / (255/(2^bits-1))); no alpha bits gives zero
    localparam logic [RECIP_W-1:0] ALPHA_RECIP [8] = '{
        RECIP_W'(0),
        RECIP_W'((RECIP_ONE + 254) / 255), RECIP_W'((RECIP_ONE + 84) / 85),
        RECIP_W'((RECIP_ONE + 35) / 36),   RECIP_W'((RECIP_ONE + 16) / 17),
        RECIP_W'((RECIP_ONE + 7) / 8),     RECIP_W'((RECIP_ONE + 3) / 4),
        RECIP_W'((RECIP_ONE + 1) / 2)
    };

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [3:0] code_bits;
        logic [3:0] per_byte;
    } pack_cfg_t;

    function automatic logic [3:0] pixels_per_byte(input logic [3:0] code_bits);
        logic [3:0] n;
        case (code_bits) inside
            4'd1:          n = 4'd8;
            4'd2:          n = 4'd4;
            [4'd3:4'd4]:   n = 4'd2;
            default:       n = 4'd1;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

/* src/gaqp_ifs.sv */
`default_nettype none

interface gaqp_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] chan_red;
    logic [7:0] chan_green;
    logic [7:0] chan_blue;
    logic [7:0] chan_alpha;
    logic       last_pixel;

    modport source (output valid, chan_red, chan_green, chan_blue, chan_alpha, last_pixel,
                    input ready);
    modport sink (input valid, chan_red, chan_green, chan_blue, chan_alpha, last_pixel,
                  output ready);
endinterface

interface gaqp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;
    logic       is_last;

    modport source (output valid, packed_byte, is_last, input ready);
    modport sink (input valid, packed_byte, is_last, output ready);
endinterface

interface gaqp_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [gaqp_pkg::CFG_INDEX_W-1:0]   index;
    logic [gaqp_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* src/gaqp_front.sv */
`default_nettype none

module gaqp_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    gaqp_pixel_if.sink               pixel,
    gaqp_cfg_if.sink                 cfg,
    output gaqp_pkg::item_t          item,
    output logic                     item_valid,
    input  wire logic                item_ready,
    output gaqp_pkg::pack_cfg_t      pcfg
);

    logic [3:0] gray_width_reg;
    logic [2:0] alpha_width_reg;
    logic [1:0] color_channels_reg;

    logic [3:0] vb_eff;
    logic [3:0] room;
    logic [2:0] ab_eff;
    logic [1:0] cc_eff;
    logic [1:0] cc_idx;
    logic [2:0] vb_idx;
    logic [3:0] code_bits;
    logic [7:0] vmax;
    logic [7:0] amax;

    logic [9:0]                          sum;
    logic [gaqp_pkg::RECIP_W-1:0]        gray_recip;
    logic [gaqp_pkg::RECIP_W-1:0]        alpha_recip;
    logic [gaqp_pkg::RECIP_W+9:0]        gray_prod;
    logic [gaqp_pkg::RECIP_W+7:0]        alpha_prod;

    logic       accept;
    logic       stage_valid_reg;
    logic       stage_valid_next;
    logic [9:0] gray_q_reg;
    logic [8:0] alpha_q_reg;
    logic       last_reg;

    logic [7:0]  gray_sat;
    logic [7:0]  alpha_sat;
    logic [15:0] code_wide;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gray_width_reg     <= gaqp_pkg::GRAY_WIDTH_RESET;
            alpha_width_reg    <= gaqp_pkg::ALPHA_WIDTH_RESET;
            color_channels_reg <= gaqp_pkg::COLOR_CHANNELS_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                gaqp_pkg::CFG_GRAY_WIDTH:     gray_width_reg     <= cfg.data;
                gaqp_pkg::CFG_ALPHA_WIDTH:    alpha_width_reg    <= cfg.data[2:0];
                gaqp_pkg::CFG_COLOR_CHANNELS: color_channels_reg <= cfg.data[1:0];
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        if (gray_width_reg == 4'd0)
            vb_eff = 4'd1;
        else if (gray_width_reg > 4'd8)
            vb_eff = 4'd8;
        else
            vb_eff = gray_width_reg;
        room   = 4'd8 - vb_eff;
        ab_eff = ({1'b0, alpha_width_reg} > room) ? room[2:0] : alpha_width_reg;
        cc_eff = (color_channels_reg == 2'd0) ? 2'd1 : color_channels_reg;
    end

    assign cc_idx    = 2'(cc_eff - 2'd1);
    assign vb_idx    = 3'(vb_eff - 4'd1);
    assign code_bits = vb_eff + {1'b0, ab_eff};
    assign vmax      = 8'((9'd1 << vb_eff) - 9'd1);
    assign amax      = 8'((9'd1 << ab_eff) - 9'd1);

    assign pcfg.code_bits = code_bits;
    assign pcfg.per_byte  = gaqp_pkg::pixels_per_byte(code_bits);

    assign sum = {2'b00, pixel.chan_red}
               + ((cc_eff >= 2'd2) ? {2'b00, pixel.chan_green} : 10'd0)
               + ((cc_eff == 2'd3) ? {2'b00, pixel.chan_blue}  : 10'd0);

    assign gray_recip  = gaqp_pkg::GRAY_RECIP[cc_idx][vb_idx];
    assign alpha_recip = gaqp_pkg::ALPHA_RECIP[ab_eff];
    assign gray_prod   = (gaqp_pkg::RECIP_W+10)'(sum) * (gaqp_pkg::RECIP_W+10)'(gray_recip);
    assign alpha_prod  = (gaqp_pkg::RECIP_W+8)'(pixel.chan_alpha)
                       * (gaqp_pkg::RECIP_W+8)'(alpha_recip);

    assign accept      = pixel.valid && pixel.ready;
    assign pixel.ready = !stage_valid_reg || item_ready;

    always_comb
    begin
        if (accept)
            stage_valid_next = 1'b1;
        else if (item_ready)
            stage_valid_next = 1'b0;
        else
            stage_valid_next = stage_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            gray_q_reg  <= gray_prod[gaqp_pkg::RECIP_SHIFT +: 10];
            alpha_q_reg <= alpha_prod[gaqp_pkg::RECIP_SHIFT +: 9];
            last_reg    <= pixel.last_pixel;
        end
    end

    assign gray_sat  = (gray_q_reg > {2'b00, vmax}) ? vmax : gray_q_reg[7:0];
    assign alpha_sat = (alpha_q_reg > {1'b0, amax}) ? amax : alpha_q_reg[7:0];
    assign code_wide = ({8'd0, gray_sat} << ab_eff) | {8'd0, alpha_sat};

    assign item.code  = code_wide[7:0];
    assign item.last  = last_reg;
    assign item_valid = stage_valid_reg;

endmodule

`default_nettype wire

/* src/gaqp_queue.sv */
`default_nettype none

`include "gray_alpha_quantize_pack_defines.svh"

module gaqp_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire gaqp_pkg::item_t push_data,
    input  wire logic            push_valid,
    output logic                 push_ready,
    output gaqp_pkg::item_t      pop_data,
    output logic                 pop_valid,
    input  wire logic            pop_ready
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    gaqp_pkg::item_t slots [DEPTH];

    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          push;
    logic          pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_data;
    end

    `GAQP_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CW'(DEPTH), "queue count over depth")
    `GAQP_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "no rise")
    `GAQP_ASSERT_NEXT(a_count_down, pop && !push, count_reg == $past(count_reg) - 1'b1, "no fall")

endmodule

`default_nettype wire

/* src/gaqp_pack.sv */
`default_nettype none

`include "gray_alpha_quantize_pack_defines.svh"

module gaqp_pack (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire gaqp_pkg::item_t     item,
    input  wire logic                item_valid,
    output logic                     item_ready,
    input  wire gaqp_pkg::pack_cfg_t pcfg,
    gaqp_byte_if.source              result
);

    logic [7:0] partial_reg;
    logic [7:0] partial_next;
    logic [2:0] slot_reg;
    logic [2:0] slot_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;

    logic        pop;
    logic        emit;
    logic        out_stall;
    logic [5:0]  shift;
    logic [15:0] code_shifted;
    logic [7:0]  merged;

    assign out_stall  = out_valid_reg && !result.ready;
    assign item_ready = !out_valid_reg || result.ready;
    assign pop        = item_valid && item_ready;

    assign shift        = 6'(slot_reg) * 6'(pcfg.code_bits);
    assign code_shifted = {8'd0, item.code} << shift[2:0];
    assign merged       = (shift < 6'd8) ? (partial_reg | code_shifted[7:0]) : partial_reg;
    assign emit         = (({1'b0, slot_reg} + 4'd1) >= pcfg.per_byte) || item.last;

    always_comb
    begin
        partial_next   = partial_reg;
        slot_next      = slot_reg;
        out_valid_next = out_valid_reg && !result.ready;
        if (pop)
        begin
            if (emit)
            begin
                partial_next   = '0;
                slot_next      = '0;
                out_valid_next = 1'b1;
            end
            else
            begin
                partial_next = merged;
                slot_next    = slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg   <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            partial_reg   <= partial_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            out_byte_reg <= merged;
            out_last_reg <= item.last;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.packed_byte = out_byte_reg;
    assign result.is_last     = out_last_reg;

    `GAQP_ASSERT_NEXT(a_stall_holds_slot, out_stall, $stable(slot_reg), "slot moved in stall")
    `GAQP_ASSERT_NEXT(a_emit_clears, pop && emit, {slot_reg, partial_reg} == '0, "not cleared")
    `GAQP_ASSERT_NEXT(a_slot_advance, pop && !emit, slot_reg == $past(slot_reg) + 1'b1, "slot stuck")

endmodule

`default_nettype wire

/* src/gray_alpha_quantize_pack.sv */
// Channel   Kind     Payload
// pixel     in       chan_red, chan_green, chan_blue, chan_alpha, last_pixel
// cfg       in       index (0 gray width, 1 alpha width, 2 color channels), data
// result    out      packed_byte, is_last
//
// One pixel per clock sustained while result is ready; divides are reciprocal multiplies in one front stage.
// A byte is loaded into the output register after its last pixel passes the front stage register and the queue.
// rst_n clears the byte being filled, the slot count, the queue and restores register defaults.
// A stalled result holds the packer; the queue and the front stage take QUEUE_DEPTH + 1
// pixels before pixel stalls.
`default_nettype none

module gray_alpha_quantize_pack #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    gaqp_pixel_if.sink       pixel,
    gaqp_cfg_if.sink         cfg,
    gaqp_byte_if.source      result
);

    gaqp_pkg::item_t     front_item;
    logic                front_valid;
    logic                front_ready;
    gaqp_pkg::item_t     back_item;
    logic                back_valid;
    logic                back_ready;
    gaqp_pkg::pack_cfg_t pcfg;

    gaqp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel      (pixel),
        .cfg        (cfg),
        .item       (front_item),
        .item_valid (front_valid),
        .item_ready (front_ready),
        .pcfg       (pcfg)
    );

    gaqp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (front_item),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_data   (back_item),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    gaqp_pack u_pack (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (back_item),
        .item_valid (back_valid),
        .item_ready (back_ready),
        .pcfg       (pcfg),
        .result     (result)
    );

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [gaqp_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_PER_SETTING = 68;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } packed_byte_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    gaqp_pixel_if pix_if ();
    gaqp_byte_if  byte_if ();
    gaqp_cfg_if   cfg_if ();

    gray_alpha_quantize_pack u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pix_if),
        .cfg    (cfg_if),
        .result (byte_if)
    );

    // shadow of the block's registers and packing state
    logic [3:0]  cfg_gray_width;
    logic [2:0]  cfg_alpha_width;
    logic [1:0]  cfg_color_channels;
    logic [7:0]  fill_byte;
    int unsigned fill_slot;

    packed_byte_t pending_bytes[$];
    packed_byte_t want;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatches = 0;
    int unsigned pixels_sent = 0;
    int unsigned bytes_checked = 0;
    int unsigned reg_writes = 0;
    int unsigned cycle_count = 0;

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            byte_if.ready <= 1'b0;
        else
            byte_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && byte_if.valid && byte_if.ready)
        begin
            bytes_checked++;
            if (pending_bytes.size() == 0)
                report_mismatch($sformatf("unexpected byte %02h last %0b",
                                          byte_if.packed_byte, byte_if.is_last));
            else
            begin
                want = pending_bytes.pop_front();
                if (byte_if.packed_byte !== want.data)
                    report_mismatch($sformatf("packed_byte %02h, expected %02h",
                                              byte_if.packed_byte, want.data));
                if (byte_if.is_last !== want.last)
                    report_mismatch($sformatf("is_last %0b, expected %0b",
                                              byte_if.is_last, want.last));
            end
        end
    end

    task automatic pack_pixel(input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue, input logic [7:0] alpha_in,
                              input logic last_in);
        int unsigned vb, ab, cc, sum, vmax, vdiv, gray, alpha, amax, bits, ppb, code, shift;
        vb = cfg_gray_width;
        if (vb == 0) vb = 1;
        if (vb > 8) vb = 8;
        ab = cfg_alpha_width;
        if (ab > 8 - vb) ab = 8 - vb;
        cc = (cfg_color_channels == 0) ? 1 : cfg_color_channels;

        sum = red;
        if (cc >= 2) sum += green;
        if (cc >= 3) sum += blue;
        vmax = (1 << vb) - 1;
        vdiv = (cc * 255) / vmax;
        gray = sum / vdiv;
        if (gray > vmax) gray = vmax;

        alpha = 0;
        if (ab != 0)
        begin
            amax = (1 << ab) - 1;
            alpha = alpha_in / (255 / amax);
            if (alpha > amax) alpha = amax;
        end

        bits = vb + ab;
        ppb = 8 / bits;
        code = ((gray << ab) | alpha) & ((1 << bits) - 1);
        shift = fill_slot * bits;
        if (shift < 8)
            fill_byte = fill_byte | 8'(code << shift);

        if (fill_slot + 1 >= ppb || last_in)
        begin
            pending_bytes.push_back('{data: fill_byte, last: last_in});
            fill_byte = 8'd0;
            fill_slot = 0;
        end
        else
            fill_slot = (fill_slot + 1) & 7;
    endtask

    task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue, input logic [7:0] alpha_in,
                              input logic last_in);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_if.valid <= 1'b0;
            @(posedge clk);
        end
        pix_if.valid      <= 1'b1;
        pix_if.chan_red   <= red;
        pix_if.chan_green <= green;
        pix_if.chan_blue  <= blue;
        pix_if.chan_alpha <= alpha_in;
        pix_if.last_pixel <= last_in;
        do
            @(posedge clk);
        while (!pix_if.ready);
        pack_pixel(red, green, blue, alpha_in, last_in);
        pixels_sent++;
    endtask

    // drop valid, wait out every expected byte and the pipeline behind it
    task automatic settle();
        pix_if.valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [gaqp_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [gaqp_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            gaqp_pkg::CFG_GRAY_WIDTH:     cfg_gray_width = value;
            gaqp_pkg::CFG_ALPHA_WIDTH:    cfg_alpha_width = value[2:0];
            gaqp_pkg::CFG_COLOR_CHANNELS: cfg_color_channels = value[1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic set_format(input logic [3:0] vb, input logic [3:0] ab,
                              input logic [3:0] cc);
        settle();
        write_reg(gaqp_pkg::CFG_GRAY_WIDTH, vb);
        write_reg(gaqp_pkg::CFG_ALPHA_WIDTH, ab);
        write_reg(gaqp_pkg::CFG_COLOR_CHANNELS, cc);
    endtask

    function automatic logic [7:0] pick_channel();
        logic [7:0] v;
        if ($urandom_range(99) < 15)
            v = $urandom_range(1) ? 8'hFF : 8'h00;
        else
            v = 8'($urandom_range(255));
        return v;
    endfunction

    task automatic test_reset_defaults();
        send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_pixel(8'hFF, 8'h00, 8'h00, 8'h00, 1'b1);
    endtask

    task automatic test_quantizer_extremes();
        set_format(4'd8, 4'd0, 4'd3);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0);
        send_pixel(8'h00, 8'h00, 8'h00, 8'hFF, 1'b1);
        set_format(4'd1, 4'd7, 4'd1);
        send_pixel(8'hFF, 8'h00, 8'h00, 8'hFF, 1'b1);
        send_pixel(8'h00, 8'hFF, 8'hFF, 8'h00, 1'b1);
    endtask

    task automatic test_register_clamps();
        set_format(4'd0, 4'd0, 4'd0);
        send_pixel(8'd200, 8'd10, 8'd10, 8'd10, 1'b1);
        set_format(4'd15, 4'd5, 4'd2);
        send_pixel(8'd128, 8'd255, 8'd3, 8'd90, 1'b1);
        set_format(4'd4, 4'd15, 4'd3);
        send_pixel(8'd77, 8'd140, 8'd33, 8'd200, 1'b1);
        settle();
        write_reg(CFG_UNUSED, 4'hF);
        send_pixel(8'd91, 8'd180, 8'd250, 8'd127, 1'b1);
    endtask

    task automatic test_stale_slot();
        set_format(4'd1, 4'd0, 4'd3);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0);
        send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0);
        set_format(4'd4, 4'd2, 4'd3);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        set_format(4'd2, 4'd0, 4'd3);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0);
        send_pixel(8'd100, 8'd100, 8'd100, 8'h00, 1'b0);
        set_format(4'd3, 4'd0, 4'd3);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0);
    endtask

    task automatic test_full_with_last();
        set_format(4'd4, 4'd0, 4'd3);
        send_pixel(8'd30, 8'd60, 8'd90, 8'd0, 1'b0);
        send_pixel(8'd240, 8'd200, 8'd220, 8'd0, 1'b1);
        set_format(4'd8, 4'd0, 4'd3);
        send_pixel(8'd17, 8'd34, 8'd51, 8'd0, 1'b1);
    endtask

    task automatic test_random_images();
        int unsigned phase, setting, count, len, i, vb;
        logic last_in;
        for (phase = 0; phase < 4; phase++)
        begin
            settle();
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 77;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 77;
                end
                default:
                begin
                    send_idle_pct = 22;
                    recv_stall_pct = 22;
                end
            endcase
            for (setting = 0; setting < 3; setting++)
            begin
                if (setting == 0)
                    case (phase)
                        0: set_format(4'd8, 4'd0, 4'd3);
                        1: set_format(4'd1, 4'd7, 4'd1);
                        2: set_format(4'd2, 4'd6, 4'd2);
                        default: set_format(4'd4, 4'd4, 4'd0);
                    endcase
                else
                begin
                    if ($urandom_range(4) == 0)
                    begin
                        vb = $urandom_range(9, 16);
                        if (vb == 16) vb = 0;
                    end
                    else
                        vb = $urandom_range(1, 8);
                    set_format(4'(vb), 4'($urandom_range(15)), 4'($urandom_range(3)));
                end
                count = 0;
                while (count < RANDOM_PER_SETTING)
                begin
                    len = $urandom_range(1, 24);
                    for (i = 0; i < len; i++)
                    begin
                        last_in = (i == len - 1);
                        if ($urandom_range(9) == 0)
                            last_in = $urandom_range(1);
                        send_pixel(pick_channel(), pick_channel(), pick_channel(),
                                   pick_channel(), last_in);
                    end
                    count += len;
                end
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin
        pix_if.valid       = 1'b0;
        pix_if.chan_red    = 8'd0;
        pix_if.chan_green  = 8'd0;
        pix_if.chan_blue   = 8'd0;
        pix_if.chan_alpha  = 8'd0;
        pix_if.last_pixel  = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = gaqp_pkg::CFG_GRAY_WIDTH;
        cfg_if.data        = '0;
        cfg_gray_width     = gaqp_pkg::GRAY_WIDTH_RESET;
        cfg_alpha_width    = gaqp_pkg::ALPHA_WIDTH_RESET;
        cfg_color_channels = gaqp_pkg::COLOR_CHANNELS_RESET;
        fill_byte          = 8'd0;
        fill_slot          = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_quantizer_extremes();
        test_register_clamps();
        test_stale_slot();
        test_full_with_last();
        test_random_images();

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d pixels, checked %0d bytes, made %0d register writes",
                 pixels_sent, bytes_checked, reg_writes);
        $display("covered reset format, clamped registers, stale slots and four idle mixes");
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
+incdir+src
src/gaqp_pkg.sv
src/gaqp_ifs.sv
src/gaqp_front.sv
src/gaqp_queue.sv
src/gaqp_pack.sv
src/gray_alpha_quantize_pack.sv
tb/sv/testbench.sv
